// ----- hdl/htl_pkg.sv -----
// Shared types, token codes and character class functions for the HTML token lexer.
package htl_pkg;

  localparam logic [3:0] KIND_IDENT       = 4'd0;
  localparam logic [3:0] KIND_VALUE       = 4'd1;
  localparam logic [3:0] KIND_DATA        = 4'd2;
  localparam logic [3:0] KIND_EQUALS      = 4'd3;
  localparam logic [3:0] KIND_OPEN        = 4'd4;
  localparam logic [3:0] KIND_OPEN_SLASH  = 4'd5;
  localparam logic [3:0] KIND_CLOSE       = 4'd6;
  localparam logic [3:0] KIND_SLASH_CLOSE = 4'd7;
  localparam logic [3:0] KIND_ERROR       = 4'd8;
  localparam logic [3:0] KIND_END         = 4'd9;

  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  // Queue between the classifier and the output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       cv;
    logic       tend;
  } result_t;

  // Up to two results caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic is_letter(input logic [7:0] c, input logic ext);
    logic plain;
    plain = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    return plain || (ext && (c >= 8'hC0 || c == 8'hA8 || c == 8'hB8));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_significant(input logic [7:0] c);
    return (c > 8'h20 && c < 8'h7F) || c >= 8'h80;
  endfunction

  function automatic result_t mk_result(input logic [3:0] kind, input logic [7:0] ch,
                                        input logic cv);
    result_t r;
    r.kind = kind;
    r.ch   = cv ? ch : 8'h00;
    r.cv   = cv;
    r.tend = ~cv;
    return r;
  endfunction

endpackage

// ----- hdl/htl_front.sv -----
// Front end: lexer state, byte classification and result pair generation.
module htl_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_write_en,
  input  logic            cfg_extended_letters,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            end_of_stream,
  output logic            push,
  output htl_pkg::entry_t entry
);

  localparam logic [2:0] M_START      = 3'd0;
  localparam logic [2:0] M_HALF_SLASH = 3'd1;
  localparam logic [2:0] M_QUOTED     = 3'd2;
  localparam logic [2:0] M_UNQUOTED   = 3'd3;
  localparam logic [2:0] M_DATA       = 3'd4;
  localparam logic [2:0] M_IDENT      = 3'd5;
  localparam logic [2:0] M_OPEN       = 3'd6;
  localparam logic [2:0] M_ENDED      = 3'd7;

  typedef struct packed {
    logic              has;
    htl_pkg::result_t  res;
    logic [2:0]        mode;
    logic [7:0]        ls;
  } start_t;

  logic [2:0] mode_r, mode_nxt;
  logic [7:0] ls_r, ls_nxt;
  logic       halt_r, halt_nxt;
  logic       ext_r;
  logic       has;
  logic       active;
  start_t     sb;

  // Handling of a byte as seen from the start mode.
  function automatic start_t start_byte(input logic [7:0] c, input logic [7:0] ls,
                                        input logic ext);
    start_t s;
    s.has  = 1'b0;
    s.res  = htl_pkg::mk_result(htl_pkg::KIND_END, 8'h00, 1'b0);
    s.mode = M_START;
    s.ls   = htl_pkg::is_significant(c) ? c : ls;
    if (c == htl_pkg::CH_EQUALS) begin
      s.has = 1'b1;
      s.res = htl_pkg::mk_result(htl_pkg::KIND_EQUALS, 8'h00, 1'b0);
    end else if (c == htl_pkg::CH_SLASH) begin
      s.mode = M_HALF_SLASH;
    end else if (c == htl_pkg::CH_QUOTE) begin
      s.mode = M_QUOTED;
    end else if (c == htl_pkg::CH_LT) begin
      s.mode = M_OPEN;
    end else if (c == htl_pkg::CH_GT) begin
      s.has = 1'b1;
      s.res = htl_pkg::mk_result(htl_pkg::KIND_CLOSE, 8'h00, 1'b0);
    end else if (htl_pkg::is_letter(c, ext) || htl_pkg::is_digit(c) ||
                 c == htl_pkg::CH_DOT || c == htl_pkg::CH_SEMI || c == htl_pkg::CH_AMP) begin
      s.has = 1'b1;
      if (ls == htl_pkg::CH_EQUALS) begin
        s.mode = M_UNQUOTED;
        s.res  = htl_pkg::mk_result(htl_pkg::KIND_VALUE, c, 1'b1);
      end else if (ls == htl_pkg::CH_GT) begin
        s.mode = M_DATA;
        s.res  = htl_pkg::mk_result(htl_pkg::KIND_DATA, c, 1'b1);
      end else begin
        s.mode = M_IDENT;
        s.res  = htl_pkg::mk_result(htl_pkg::KIND_IDENT, c, 1'b1);
      end
    end
    return s;
  endfunction

  assign active = ~halt_r && (mode_r != M_ENDED);

  always_comb begin
    sb       = start_byte(data_byte, ls_r, ext_r);
    mode_nxt = mode_r;
    ls_nxt   = ls_r;
    halt_nxt = halt_r;
    has      = 1'b0;
    entry    = '0;
    unique case (mode_r)
      M_HALF_SLASH: begin
        has = 1'b1;
        if (!end_of_stream && data_byte == htl_pkg::CH_GT) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_SLASH_CLOSE, 8'h00, 1'b0);
          ls_nxt   = htl_pkg::CH_GT;
          mode_nxt = M_START;
        end else begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_ERROR, 8'h00, 1'b0);
          halt_nxt = 1'b1;
        end
      end
      M_QUOTED: begin
        has = 1'b1;
        if (end_of_stream) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_ERROR, 8'h00, 1'b0);
          halt_nxt = 1'b1;
        end else if (data_byte == htl_pkg::CH_QUOTE) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_VALUE, 8'h00, 1'b0);
          ls_nxt   = htl_pkg::CH_QUOTE;
          mode_nxt = M_START;
        end else begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_VALUE, data_byte, 1'b1);
          if (htl_pkg::is_significant(data_byte)) ls_nxt = data_byte;
        end
      end
      M_UNQUOTED: begin
        has = 1'b1;
        if (end_of_stream) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_ERROR, 8'h00, 1'b0);
          halt_nxt = 1'b1;
        end else if (data_byte == htl_pkg::CH_SPACE) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_VALUE, 8'h00, 1'b0);
          mode_nxt = M_START;
        end else if (data_byte == htl_pkg::CH_GT) begin
          entry.r0  = htl_pkg::mk_result(htl_pkg::KIND_VALUE, 8'h00, 1'b0);
          entry.two = sb.has;
          entry.r1  = sb.res;
          mode_nxt  = sb.mode;
          ls_nxt    = sb.ls;
        end else begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_VALUE, data_byte, 1'b1);
          if (htl_pkg::is_significant(data_byte)) ls_nxt = data_byte;
        end
      end
      M_DATA: begin
        has = 1'b1;
        if (end_of_stream) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_ERROR, 8'h00, 1'b0);
          halt_nxt = 1'b1;
        end else if (data_byte == htl_pkg::CH_LT) begin
          entry.r0  = htl_pkg::mk_result(htl_pkg::KIND_DATA, 8'h00, 1'b0);
          entry.two = sb.has;
          entry.r1  = sb.res;
          mode_nxt  = sb.mode;
          ls_nxt    = sb.ls;
        end else begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_DATA, data_byte, 1'b1);
          if (htl_pkg::is_significant(data_byte)) ls_nxt = data_byte;
        end
      end
      M_IDENT: begin
        has = 1'b1;
        if (end_of_stream) begin
          entry.r0  = htl_pkg::mk_result(htl_pkg::KIND_IDENT, 8'h00, 1'b0);
          entry.two = 1'b1;
          entry.r1  = htl_pkg::mk_result(htl_pkg::KIND_END, 8'h00, 1'b0);
          mode_nxt  = M_ENDED;
        end else if (htl_pkg::is_letter(data_byte, ext_r) || htl_pkg::is_digit(data_byte) ||
                     data_byte == htl_pkg::CH_DOT || data_byte == htl_pkg::CH_UNDER ||
                     data_byte == htl_pkg::CH_DASH) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_IDENT, data_byte, 1'b1);
          ls_nxt   = data_byte;
        end else begin
          entry.r0  = htl_pkg::mk_result(htl_pkg::KIND_IDENT, 8'h00, 1'b0);
          entry.two = sb.has;
          entry.r1  = sb.res;
          mode_nxt  = sb.mode;
          ls_nxt    = sb.ls;
        end
      end
      M_OPEN: begin
        has = 1'b1;
        if (end_of_stream) begin
          entry.r0  = htl_pkg::mk_result(htl_pkg::KIND_OPEN, 8'h00, 1'b0);
          entry.two = 1'b1;
          entry.r1  = htl_pkg::mk_result(htl_pkg::KIND_END, 8'h00, 1'b0);
          mode_nxt  = M_ENDED;
        end else if (data_byte == htl_pkg::CH_SLASH) begin
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_OPEN_SLASH, 8'h00, 1'b0);
          ls_nxt   = htl_pkg::CH_SLASH;
          mode_nxt = M_START;
        end else begin
          entry.r0  = htl_pkg::mk_result(htl_pkg::KIND_OPEN, 8'h00, 1'b0);
          entry.two = sb.has;
          entry.r1  = sb.res;
          mode_nxt  = sb.mode;
          ls_nxt    = sb.ls;
        end
      end
      M_ENDED: begin
        has = 1'b0;
      end
      default: begin
        if (end_of_stream) begin
          has      = 1'b1;
          entry.r0 = htl_pkg::mk_result(htl_pkg::KIND_END, 8'h00, 1'b0);
          mode_nxt = M_ENDED;
        end else begin
          has      = sb.has;
          entry.r0 = sb.res;
          mode_nxt = sb.mode;
          ls_nxt   = sb.ls;
        end
      end
    endcase
  end

  assign push = accept && active && has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      ls_r   <= 8'h00;
      halt_r <= 1'b0;
      ext_r  <= 1'b1;
    end else begin
      if (accept && active) begin
        mode_r <= mode_nxt;
        ls_r   <= ls_nxt;
        halt_r <= halt_nxt;
      end
      if (cfg_write_en) ext_r <= cfg_extended_letters;
    end
  end

endmodule

// ----- hdl/htl_queue.sv -----
// Small FIFO of result pairs between the front end and the output stage.
module htl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  htl_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output htl_pkg::entry_t rdata
);

  htl_pkg::entry_t          mem_r [htl_pkg::QDEPTH];
  logic [htl_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [htl_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (htl_pkg::QPTR_W+1)'(htl_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/htl_back.sv -----
// Output stage: splits result pairs into single transfers and holds the output register.
module htl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  htl_pkg::entry_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      out_token_kind,
  output logic [7:0]      out_char_out,
  output logic            out_char_valid,
  output logic            out_token_end,
  output logic            out_last
);

  logic             valid_r;
  logic             sel_r;
  logic             load;
  logic             is_last;
  htl_pkg::result_t res_r, res_nxt;
  logic             last_r;

  assign load    = !q_empty && (!valid_r || !out_stall);
  assign res_nxt = sel_r ? q_data.r1 : q_data.r0;
  assign is_last = sel_r || !q_data.two;
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sel_r   <= ~is_last;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= res_nxt;
      last_r <= is_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_token_kind = res_r.kind;
  assign out_char_out   = res_r.ch;
  assign out_char_valid = res_r.cv;
  assign out_token_end  = res_r.tend;
  assign out_last       = last_r;

endmodule

// ----- hdl/html_token_lexer.sv -----
// Top level of the byte-serial HTML token lexer.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------------
//   in_      | input     | in_valid/in_stall  | data_byte, end_of_stream
//   out_     | output    | out_valid/out_stall| token_kind, char_out, char_valid,
//            |           |                    | token_end, last
//   cfg_     | input     | cfg_write_en       | extended_letters
//
// One input byte is accepted per cycle while the four-entry result queue has room.
// Each byte yields zero, one or two results; the output stage sends one result per
// cycle while out_stall is low, so a byte that yields two results takes two transfers.
// The first result of a byte goes through the queue write and then the output register
// before it is offered on out_; a stall on the output can hold it back in the queue.
// Reset is synchronous and active low; it restores the start mode and enables cp1251 letters.
// A stall on the output only fills the queue; the input stalls once the queue is full.
module html_token_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic       cfg_extended_letters,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_char_out,
  output logic       out_char_valid,
  output logic       out_token_end,
  output logic       out_last
);

  logic            accept;
  logic            push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  htl_pkg::entry_t push_entry;
  htl_pkg::entry_t head_entry;

  // The input is held off only by a full queue; a halted or ended lexer still
  // takes transfers and simply drops them.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // The front end keeps the lexer mode, the last significant byte and the halt
  // flag, and turns each byte into up to two results (pushed-back bytes are
  // handled in the same cycle by a second result).
  htl_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_extended_letters (cfg_extended_letters),
    .accept               (accept),
    .data_byte            (in_data_byte),
    .end_of_stream        (in_end_of_stream),
    .push                 (push),
    .entry                (push_entry)
  );

  // The queue decouples classification from output back-pressure.
  htl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_entry),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (head_entry)
  );

  // The back end serializes each pair and marks the final result of a byte.
  htl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (head_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_char_out   (out_char_out),
    .out_char_valid (out_char_valid),
    .out_token_end  (out_token_end),
    .out_last       (out_last)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for html_token_lexer: directed and random byte streams.
`timescale 1ns / 100ps

module tb_top;

  // Lexer modes of the scoreboard's own copy of the block.
  typedef enum logic [3:0] {
    MODE_START,
    MODE_HALF_SLASH,
    MODE_QUOTED,
    MODE_UNQUOTED,
    MODE_DATA,
    MODE_IDENT,
    MODE_OPEN,
    MODE_ENDED
  } lex_mode_t;

  // One token result as it leaves the out_ channel.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       cv;
    logic       tend;
    logic       last_flag;
  } token_t;

  // One row of the directed stream. Rows with typed set carry their own expected token.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    token_t     want;
  } stim_row_t;

  localparam int DIR_ROWS    = 25;
  localparam int CFG_SETTLE  = 6;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 2000;
  localparam int EXP_DEPTH   = 4096;

  logic       clk;
  logic       rst_n;
  logic       cfg_write_en;
  logic       cfg_extended_letters;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_end_of_stream;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_token_kind;
  logic [7:0] out_char_out;
  logic       out_char_valid;
  logic       out_token_end;
  logic       out_last;

  // Lexer state as predicted from the accepted transfers, plus the letter setting.
  lex_mode_t  lex_mode;
  logic [7:0] last_sig;
  logic       lex_halted;
  logic       ext_letters;

  // Tokens caused by the transfer being predicted, and the tokens still owed by the block.
  // The owed tokens sit in a ring: exp_wr counts stored tokens, exp_rd counts checked ones.
  token_t     step_tok [2];
  int         step_n;
  token_t     tok_expect [EXP_DEPTH];
  int         exp_wr;
  int         exp_rd;

  token_t     got_tok;
  token_t     want_tok;
  int         mismatches;
  int         in_gap_pct;
  int         out_stall_pct;

  // The directed stream starts right after reset with cp1251 letters enabled. It walks
  // through ident, quoted value, attribute, unquoted value, close, data, open slash,
  // open with reprocessed byte, slash close, and a silent significant byte in start mode.
  stim_row_t dir_rows [DIR_ROWS] = '{
    {8'h61,              1'b0, 1'b1, htl_pkg::KIND_IDENT, 8'h61, 1'b1, 1'b0, 1'b1},
    {8'hFF,              1'b0, 1'b1, htl_pkg::KIND_IDENT, 8'hFF, 1'b1, 1'b0, 1'b1},
    {htl_pkg::CH_SPACE,  1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_EQUALS, 1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_QUOTE,  1'b0, 1'b0, 15'd0},
    {8'h00,              1'b0, 1'b1, htl_pkg::KIND_VALUE, 8'h00, 1'b1, 1'b0, 1'b1},
    {8'hC0,              1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_QUOTE,  1'b0, 1'b0, 15'd0},
    {8'h68,              1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_EQUALS, 1'b0, 1'b0, 15'd0},
    {8'h35,              1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_GT,     1'b0, 1'b0, 15'd0},
    {8'h54,              1'b0, 1'b0, 15'd0},
    {8'h7F,              1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_LT,     1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_SLASH,  1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_DOT,    1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_GT,     1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_LT,     1'b0, 1'b0, 15'd0},
    {8'h62,              1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_SLASH,  1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_GT,     1'b0, 1'b0, 15'd0},
    {8'h80,              1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_AMP,    1'b0, 1'b0, 15'd0},
    {htl_pkg::CH_SEMI,   1'b0, 1'b0, 15'd0}
  };

  html_token_lexer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_extended_letters (cfg_extended_letters),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_end_of_stream     (in_end_of_stream),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_token_kind       (out_token_kind),
    .out_char_out         (out_char_out),
    .out_char_valid       (out_char_valid),
    .out_token_end        (out_token_end),
    .out_last             (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Character classes. Extended letters depend on the current register value.
  // ---------------------------------------------------------------------------
  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (ext_letters && (c >= 8'hC0 || c == 8'hA8 || c == 8'hB8));
  endfunction

  // Bytes that may open a word in the start mode.
  function automatic logic word_head(input logic [7:0] c);
    return letter_byte(c) || (c >= 8'h30 && c <= 8'h39) ||
           c == htl_pkg::CH_DOT || c == htl_pkg::CH_SEMI || c == htl_pkg::CH_AMP;
  endfunction

  // Bytes that keep an ident going.
  function automatic logic word_tail(input logic [7:0] c);
    return letter_byte(c) || (c >= 8'h30 && c <= 8'h39) ||
           c == htl_pkg::CH_DOT || c == htl_pkg::CH_UNDER || c == htl_pkg::CH_DASH;
  endfunction

  // Neither white space nor control: these bytes are remembered as the last significant one.
  function automatic logic sig_byte(input logic [7:0] c);
    return (c > 8'h20 && c < 8'h7F) || c >= 8'h80;
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor.
  // ---------------------------------------------------------------------------
  // Streamed bytes carry char_valid and no token end; every other token is a token end
  // with a zero character.
  function automatic void add_tok(input logic [3:0] kind, input logic [7:0] c, input logic cv);
    if (step_n < 2) begin
      step_tok[step_n] = {kind, cv ? c : 8'h00, cv, !cv, 1'b0};
      step_n++;
    end
  endfunction

  // Handles a byte in the start mode. A byte that closed the previous token comes back
  // here within the same transfer, so a single byte can yield two tokens.
  function automatic void enter_start(input logic [7:0] c);
    lex_mode = MODE_START;
    if (c == htl_pkg::CH_EQUALS) begin
      add_tok(htl_pkg::KIND_EQUALS, 8'h00, 1'b0);
    end else if (c == htl_pkg::CH_SLASH) begin
      lex_mode = MODE_HALF_SLASH;
    end else if (c == htl_pkg::CH_QUOTE) begin
      lex_mode = MODE_QUOTED;
    end else if (c == htl_pkg::CH_LT) begin
      lex_mode = MODE_OPEN;
    end else if (c == htl_pkg::CH_GT) begin
      add_tok(htl_pkg::KIND_CLOSE, 8'h00, 1'b0);
    end else if (word_head(c)) begin
      // The last significant byte decides what kind of word this is.
      if (last_sig == htl_pkg::CH_EQUALS) begin
        lex_mode = MODE_UNQUOTED;
        add_tok(htl_pkg::KIND_VALUE, c, 1'b1);
      end else if (last_sig == htl_pkg::CH_GT) begin
        lex_mode = MODE_DATA;
        add_tok(htl_pkg::KIND_DATA, c, 1'b1);
      end else begin
        lex_mode = MODE_IDENT;
        add_tok(htl_pkg::KIND_IDENT, c, 1'b1);
      end
    end
    if (sig_byte(c)) begin
      last_sig = c;
    end
  endfunction

  // Advances the predicted state by one accepted transfer and leaves its tokens in step_tok.
  function automatic void predict_tokens(input logic [7:0] c, input logic eos);
    logic broken;
    broken = 1'b0;
    step_n = 0;
    // Once halted or ended, the block swallows everything until reset.
    if (lex_halted || lex_mode == MODE_ENDED) begin
      return;
    end
    case (lex_mode)
      MODE_HALF_SLASH: begin
        if (!eos && c == htl_pkg::CH_GT) begin
          add_tok(htl_pkg::KIND_SLASH_CLOSE, 8'h00, 1'b0);
          last_sig = htl_pkg::CH_GT;
          lex_mode = MODE_START;
        end else begin
          broken = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (eos) begin
          broken = 1'b1;
        end else if (c == htl_pkg::CH_QUOTE) begin
          add_tok(htl_pkg::KIND_VALUE, 8'h00, 1'b0);
          last_sig = htl_pkg::CH_QUOTE;
          lex_mode = MODE_START;
        end else begin
          add_tok(htl_pkg::KIND_VALUE, c, 1'b1);
          if (sig_byte(c)) last_sig = c;
        end
      end
      MODE_UNQUOTED: begin
        if (eos) begin
          broken = 1'b1;
        end else if (c == htl_pkg::CH_SPACE) begin
          add_tok(htl_pkg::KIND_VALUE, 8'h00, 1'b0);
          lex_mode = MODE_START;
        end else if (c == htl_pkg::CH_GT) begin
          add_tok(htl_pkg::KIND_VALUE, 8'h00, 1'b0);
          last_sig = htl_pkg::CH_GT;
          enter_start(c);
        end else begin
          add_tok(htl_pkg::KIND_VALUE, c, 1'b1);
          if (sig_byte(c)) last_sig = c;
        end
      end
      MODE_DATA: begin
        if (eos) begin
          broken = 1'b1;
        end else if (c == htl_pkg::CH_LT) begin
          add_tok(htl_pkg::KIND_DATA, 8'h00, 1'b0);
          last_sig = htl_pkg::CH_LT;
          enter_start(c);
        end else begin
          add_tok(htl_pkg::KIND_DATA, c, 1'b1);
          if (sig_byte(c)) last_sig = c;
        end
      end
      MODE_IDENT: begin
        if (eos) begin
          add_tok(htl_pkg::KIND_IDENT, 8'h00, 1'b0);
          add_tok(htl_pkg::KIND_END, 8'h00, 1'b0);
          lex_mode = MODE_ENDED;
        end else if (word_tail(c)) begin
          add_tok(htl_pkg::KIND_IDENT, c, 1'b1);
          last_sig = c;
        end else begin
          add_tok(htl_pkg::KIND_IDENT, 8'h00, 1'b0);
          enter_start(c);
        end
      end
      MODE_OPEN: begin
        if (eos) begin
          add_tok(htl_pkg::KIND_OPEN, 8'h00, 1'b0);
          add_tok(htl_pkg::KIND_END, 8'h00, 1'b0);
          lex_mode = MODE_ENDED;
        end else if (c == htl_pkg::CH_SLASH) begin
          add_tok(htl_pkg::KIND_OPEN_SLASH, 8'h00, 1'b0);
          last_sig = htl_pkg::CH_SLASH;
          lex_mode = MODE_START;
        end else begin
          add_tok(htl_pkg::KIND_OPEN, 8'h00, 1'b0);
          enter_start(c);
        end
      end
      default: begin
        if (eos) begin
          add_tok(htl_pkg::KIND_END, 8'h00, 1'b0);
          lex_mode = MODE_ENDED;
        end else begin
          enter_start(c);
        end
      end
    endcase
    if (broken) begin
      add_tok(htl_pkg::KIND_ERROR, 8'h00, 1'b0);
      lex_halted = 1'b1;
    end
    if (step_n > 0) begin
      step_tok[step_n - 1].last_flag = 1'b1;
    end
  endfunction

  // Appends one token to the ring of tokens owed by the block.
  function automatic void owe_token(input token_t t);
    tok_expect[exp_wr % EXP_DEPTH] = t;
    exp_wr++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  // A byte that belongs in a word: plain and cp1251 letters, digits and word punctuation.
  function automatic logic [7:0] word_byte();
    case ($urandom_range(7))
      0, 1: begin
        return 8'(8'h61 + $urandom_range(25));
      end
      2: begin
        return 8'(8'h41 + $urandom_range(25));
      end
      3: begin
        return 8'(8'h30 + $urandom_range(9));
      end
      4: begin
        return 8'(8'hC0 + $urandom_range(63));
      end
      5: begin
        return ($urandom_range(1) != 0) ? 8'hA8 : 8'hB8;
      end
      6: begin
        return ($urandom_range(1) != 0) ? htl_pkg::CH_DOT : htl_pkg::CH_SEMI;
      end
      default: begin
        return ($urandom_range(1) != 0) ? htl_pkg::CH_UNDER :
               (($urandom_range(1) != 0) ? htl_pkg::CH_DASH : htl_pkg::CH_AMP);
      end
    endcase
  endfunction

  // Picks the next byte from the predicted mode so that the stream looks like markup:
  // tags, attributes with both kinds of values, and text between tags. A small share
  // of fully random bytes is mixed in except after a lone slash, where only the closing
  // bracket is allowed, since anything else would halt the block for the rest of the run.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (lex_mode == MODE_HALF_SLASH) begin
      return htl_pkg::CH_GT;
    end
    if (r < 8) begin
      return 8'($urandom_range(255));
    end
    case (lex_mode)
      MODE_QUOTED: begin
        return (r < 25) ? htl_pkg::CH_QUOTE : 8'($urandom_range(255));
      end
      MODE_UNQUOTED: begin
        return (r < 22) ? htl_pkg::CH_SPACE : (r < 32) ? htl_pkg::CH_GT : word_byte();
      end
      MODE_DATA: begin
        return (r < 20) ? htl_pkg::CH_LT : (r < 30) ? htl_pkg::CH_SPACE : word_byte();
      end
      MODE_IDENT: begin
        return (r < 20) ? htl_pkg::CH_SPACE : (r < 30) ? htl_pkg::CH_EQUALS :
               (r < 38) ? htl_pkg::CH_GT : (r < 44) ? htl_pkg::CH_SLASH : word_byte();
      end
      MODE_OPEN: begin
        return (r < 35) ? htl_pkg::CH_SLASH : word_byte();
      end
      default: begin
        return (r < 16) ? htl_pkg::CH_EQUALS : (r < 26) ? htl_pkg::CH_QUOTE :
               (r < 40) ? htl_pkg::CH_LT : (r < 52) ? htl_pkg::CH_GT :
               (r < 58) ? htl_pkg::CH_SLASH : (r < 66) ? htl_pkg::CH_SPACE : word_byte();
      end
    endcase
  endfunction

  // Offers one item on the in_ channel and holds it until the transfer takes place.
  // in_valid is left high afterwards; between items it drops only for the random gaps.
  // The expected tokens are queued at the transfer; the first of them has to pass the
  // queue and the output register before it can come out.
  task automatic send_item(input logic [7:0] c, input logic eos, input logic typed,
                           input token_t want);
    int k;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= c;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_tokens(c, eos);
    if (typed) begin
      owe_token(want);
    end else begin
      for (k = 0; k < step_n; k++) begin
        owe_token(step_tok[k]);
      end
    end
  endtask

  // Writes the letter setting once the block has gone quiet. An item may have produced
  // no token, so a settle time after the last token covers whatever is still in flight.
  task automatic write_letters(input logic val);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) begin
      @(posedge clk);
    end
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_write_en         <= 1'b1;
    cfg_extended_letters <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    ext_letters  = val;
  endtask

  task automatic run_markup(input int gap_pct, input int stall_pct, input int count);
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    repeat (count) send_item(pick_byte(), 1'b0, 1'b0, '0);
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every out_ transfer is compared with the oldest expected token.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      exp_rd     = 0;
      mismatches = 0;
    end else if (out_valid && !out_stall) begin
      got_tok = {out_token_kind, out_char_out, out_char_valid, out_token_end, out_last};
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected token: kind %0d char %02h char_valid %0b token_end %0b last %0b",
                   got_tok.kind, got_tok.ch, got_tok.cv, got_tok.tend, got_tok.last_flag);
        end
      end else begin
        want_tok = tok_expect[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got_tok !== want_tok) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch (expected/actual): kind %0d/%0d char %02h/%02h",
                     want_tok.kind, got_tok.kind, want_tok.ch, got_tok.ch);
            $display("  char_valid %0b/%0b token_end %0b/%0b last %0b/%0b",
                     want_tok.cv, got_tok.cv, want_tok.tend, got_tok.tend,
                     want_tok.last_flag, got_tok.last_flag);
          end
        end
      end
    end
  end

  // The run is abandoned once nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         i;
    int         guard;
    lex_mode_t  target;
    logic [7:0] bad;
    lex_mode_t  finale [7];

    finale = '{MODE_START, MODE_IDENT, MODE_OPEN, MODE_QUOTED, MODE_UNQUOTED, MODE_DATA,
               MODE_HALF_SLASH};

    rst_n                <= 1'b0;
    cfg_write_en         <= 1'b0;
    cfg_extended_letters <= 1'b0;
    in_valid             <= 1'b0;
    in_data_byte         <= 8'h00;
    in_end_of_stream     <= 1'b0;
    exp_wr        = 0;
    in_gap_pct    = 28;
    out_stall_pct = 84;

    // The predictor starts from the reset state, with cp1251 letters enabled.
    lex_mode    = MODE_START;
    last_sig    = 8'h00;
    lex_halted  = 1'b0;
    ext_letters = 1'b1;
    step_n      = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed stream under the reset setting of the letter register.
    for (i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random markup in three phases: a slow receiver, then a slow sender, then full rate.
    // The letter setting is written before each phase: off, then on, then at random.
    write_letters(1'b0);
    run_markup(28, 84, 330);
    write_letters(1'b1);
    run_markup(84, 28, 330);
    write_letters(1'($urandom_range(1)));
    run_markup(0, 0, 340);

    // The stream can finish only once, since the block then waits for a reset. Steer the
    // lexer into one mode chosen at random and end there: a clean stream end from start,
    // ident or open bracket, or an error from an open value, text data or a lone slash.
    target = finale[$urandom_range(6)];
    guard  = 0;
    while (lex_mode != target && guard < 300) begin
      send_item(pick_byte(), 1'b0, 1'b0, '0);
      guard++;
    end
    if (lex_mode == MODE_HALF_SLASH) begin
      bad = 8'($urandom_range(255));
      while (bad == htl_pkg::CH_GT) begin
        bad = 8'($urandom_range(255));
      end
      send_item(bad, 1'b0, 1'b0, '0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    end

    // Whatever comes after the end or the error must be swallowed without a token.
    repeat (5) send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);

    in_valid <= 1'b0;
    while (exp_wr != exp_rd) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
